// ===== rtl/dtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dtbs_pkg: shared types and constants of the date-time borrow subtractor
// Field width, radices, month codes, the stage records that pass between
// the pipeline stages, and the two-month window table.
// ----------------------------------------------------------------------------
package dtbs_pkg;

  localparam int unsigned FIELD_W = 8;
  localparam int unsigned CALC_W  = 11;
  localparam int unsigned IN_W    = 128;
  localparam int unsigned OUT_W   = 64;

  typedef logic [FIELD_W-1:0]       byte_t;
  typedef logic signed [CALC_W-1:0] sval_t;

  localparam sval_t HUND_RADIX  = 11'sd100;
  localparam sval_t SEC_RADIX   = 11'sd60;
  localparam sval_t MIN_RADIX   = 11'sd60;
  localparam sval_t HOUR_RADIX  = 11'sd24;
  localparam sval_t MONTH_RADIX = 11'sd12;
  localparam sval_t YEAR_RADIX  = 11'sd100;
  localparam sval_t YEAR_MAX    = 11'sd99;
  localparam sval_t FEB_SPAN    = 11'sd28;
  localparam sval_t SPAN_30     = 11'sd30;
  localparam sval_t SPAN_31     = 11'sd31;
  localparam sval_t MONTH_BACK  = 11'sd2;

  localparam sval_t MON_JAN = 11'sd1;
  localparam sval_t MON_FEB = 11'sd2;
  localparam sval_t MON_MAR = 11'sd3;
  localparam sval_t MON_APR = 11'sd4;
  localparam sval_t MON_MAY = 11'sd5;
  localparam sval_t MON_JUN = 11'sd6;
  localparam sval_t MON_JUL = 11'sd7;
  localparam sval_t MON_AUG = 11'sd8;
  localparam sval_t MON_SEP = 11'sd9;
  localparam sval_t MON_OCT = 11'sd10;
  localparam sval_t MON_NOV = 11'sd11;
  localparam sval_t MON_DEC = 11'sd12;

  // Stage 1 record: low time fields done, month done, rest still raw.
  typedef struct packed {
    byte_t hund;
    byte_t sec;
    logic  sec_owe;
    byte_t m_min;
    byte_t s_min;
    byte_t m_hour;
    byte_t s_hour;
    sval_t day_raw;
    sval_t mon;
    logic  year_owe;
    byte_t m_year;
    byte_t s_year;
    byte_t m_cent;
    byte_t s_cent;
  } s1_t;

  // Stage 2 record: time fields done, date fields ready for the day borrow.
  typedef struct packed {
    byte_t hund;
    byte_t sec;
    byte_t min;
    byte_t hour;
    logic  hour_owe;
    sval_t day_raw;
    sval_t mon;
    logic  leap;
    sval_t year;
    sval_t cent;
  } s2_t;

  typedef struct packed {
    byte_t cent;
    byte_t year;
    byte_t mon;
    byte_t day;
    byte_t hour;
    byte_t min;
    byte_t sec;
    byte_t hund;
  } res_t;

  function automatic sval_t ext(input byte_t v);
    ext = sval_t'({3'b000, v});
  endfunction

  // Window length minus subtracted month length, for a known month.
  function automatic sval_t window_span(input sval_t mon, input logic leap, input sval_t d);
    sval_t span;
    span = d;
    unique case (mon)
      MON_DEC, MON_OCT, MON_JUL, MON_MAY: span = SPAN_30;
      MON_NOV, MON_AUG, MON_JUN, MON_JAN: span = SPAN_31;
      MON_FEB, MON_SEP:                   span = SPAN_31;
      MON_MAR:                            span = FEB_SPAN + sval_t'({10'd0, leap});
      MON_APR:                            span = SPAN_31;
      default:                            span = d;
    endcase
    window_span = span;
  endfunction

endpackage

// ===== rtl/dtbs_window.sv =====
// ----------------------------------------------------------------------------
// dtbs_window: day borrow stage
// Applies the two-month window when the day difference is not positive,
// steps the month back with year and century wrap, and forms the result.
// ----------------------------------------------------------------------------
module dtbs_window (
  input  dtbs_pkg::s2_t  stg,
  output dtbs_pkg::res_t res
);

  dtbs_pkg::sval_t d;
  dtbs_pkg::sval_t day;
  dtbs_pkg::sval_t mon;
  dtbs_pkg::sval_t year;
  dtbs_pkg::sval_t cent;

  always_comb begin
    d    = stg.day_raw - dtbs_pkg::sval_t'({10'd0, stg.hour_owe});
    day  = d;
    mon  = stg.mon;
    year = stg.year;
    cent = stg.cent;
    if (d <= 0) begin
      day = d + dtbs_pkg::window_span(stg.mon, stg.leap, d);
      mon = stg.mon - dtbs_pkg::MONTH_BACK;
      if (mon < 0) begin
        mon  = mon + dtbs_pkg::MONTH_RADIX;
        year = stg.year - 11'sd1;
        if (year < 0) begin
          year = dtbs_pkg::YEAR_MAX;
          cent = stg.cent - 11'sd1;
        end
      end
      if (day > 0) begin
        mon = mon + 11'sd1;
      end
    end

    res.hund = stg.hund;
    res.sec  = stg.sec;
    res.min  = stg.min;
    res.hour = stg.hour;
    res.day  = day[dtbs_pkg::FIELD_W-1:0];
    res.mon  = mon[dtbs_pkg::FIELD_W-1:0];
    res.year = year[dtbs_pkg::FIELD_W-1:0];
    res.cent = cent[dtbs_pkg::FIELD_W-1:0];
  end

endmodule

// ===== rtl/datetime_borrow_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// datetime_borrow_subtractor_core: field-wise date-time subtractor
// Subtracts a packed subtrahend date-time from a packed minuend date-time
// through a three-stage pipeline with a borrow chain over the time fields
// and a window borrow on the day.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata layout (lowest bit up)            | width
//  --------+-----------+-----------------------------------------+------
//  in_     | slave     | minuend_time, minuend_date,             | 128
//          |           | subtrahend_time, subtrahend_date        |
//  out_    | master    | diff_hundredths, second, minute, hour,  | 64
//          |           | day, month, year, century               |
//
//  One word enters per cycle while in_tready is high; each word's result
//  is presented from the output register once it has passed all three
//  register stages: two internal stages plus the output register.
//  The sustained rate is one word per cycle: every stage advances whenever
//  the stage after it is empty or moving.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stall on out_tready holds every occupied stage and backs up to
//  in_tready; empty stages keep filling, so nothing is lost or repeated.
//
module datetime_borrow_subtractor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // minuend_time[31:0], minuend_date[63:32],
  // subtrahend_time[95:64], subtrahend_date[127:96]
  input  logic [dtbs_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // diff_hundredths[7:0], diff_second[15:8], diff_minute[23:16],
  // diff_hour[31:24], diff_day[39:32], diff_month[47:40],
  // diff_year[55:48], diff_century[63:56]
  output logic [dtbs_pkg::OUT_W-1:0]   out_tdata
);

  // Stage handshake: each stage moves when the next is free or moving.
  logic adv_out;
  logic adv_s2;
  logic adv_s1;

  logic           s1_v_r;
  logic           s2_v_r;
  logic           out_v_r;
  dtbs_pkg::s1_t  s1_r;
  dtbs_pkg::s1_t  s1_nxt;
  dtbs_pkg::s2_t  s2_r;
  dtbs_pkg::s2_t  s2_nxt;
  dtbs_pkg::res_t res;
  dtbs_pkg::res_t out_r;

  assign adv_out   = !out_v_r || out_tready;
  assign adv_s2    = !s2_v_r || adv_out;
  assign adv_s1    = !s1_v_r || adv_s2;
  assign in_tready = adv_s1;

  // Stage 1: hundredths and seconds of the time chain, month with year
  // borrow, raw day difference.
  always_comb begin
    dtbs_pkg::sval_t hund;
    dtbs_pkg::sval_t sec;
    dtbs_pkg::sval_t mon;
    logic            hb;
    logic            sb;
    logic            yb;

    hund = dtbs_pkg::ext(in_tdata[7:0]) - dtbs_pkg::ext(in_tdata[71:64]);
    hb   = (hund < 0);
    if (hb) begin
      hund = hund + dtbs_pkg::HUND_RADIX;
    end
    sec = dtbs_pkg::ext(in_tdata[15:8]) - dtbs_pkg::ext(in_tdata[79:72])
        - dtbs_pkg::sval_t'({10'd0, hb});
    sb  = (sec < 0);
    if (sb) begin
      sec = sec + dtbs_pkg::SEC_RADIX;
    end
    mon = dtbs_pkg::ext(in_tdata[47:40]) - dtbs_pkg::ext(in_tdata[111:104]);
    yb  = (mon < 0);
    if (yb) begin
      mon = mon + dtbs_pkg::MONTH_RADIX;
    end

    s1_nxt.hund     = hund[dtbs_pkg::FIELD_W-1:0];
    s1_nxt.sec      = sec[dtbs_pkg::FIELD_W-1:0];
    s1_nxt.sec_owe  = sb;
    s1_nxt.m_min    = in_tdata[23:16];
    s1_nxt.s_min    = in_tdata[87:80];
    s1_nxt.m_hour   = in_tdata[31:24];
    s1_nxt.s_hour   = in_tdata[95:88];
    s1_nxt.day_raw  = dtbs_pkg::ext(in_tdata[39:32]) - dtbs_pkg::ext(in_tdata[103:96]);
    s1_nxt.mon      = mon;
    s1_nxt.year_owe = yb;
    s1_nxt.m_year   = in_tdata[55:48];
    s1_nxt.s_year   = in_tdata[119:112];
    s1_nxt.m_cent   = in_tdata[63:56];
    s1_nxt.s_cent   = in_tdata[127:120];
  end

  // Stage 2: minutes and hours, year with century borrow, zero-month fix,
  // leap flag for the window table.
  always_comb begin
    dtbs_pkg::sval_t min;
    dtbs_pkg::sval_t hour;
    dtbs_pkg::sval_t year;
    dtbs_pkg::sval_t mon;
    logic            mb;
    logic            hrb;
    logic            cb;

    min = dtbs_pkg::ext(s1_r.m_min) - dtbs_pkg::ext(s1_r.s_min)
        - dtbs_pkg::sval_t'({10'd0, s1_r.sec_owe});
    mb  = (min < 0);
    if (mb) begin
      min = min + dtbs_pkg::MIN_RADIX;
    end
    hour = dtbs_pkg::ext(s1_r.m_hour) - dtbs_pkg::ext(s1_r.s_hour)
         - dtbs_pkg::sval_t'({10'd0, mb});
    hrb  = (hour < 0);
    if (hrb) begin
      hour = hour + dtbs_pkg::HOUR_RADIX;
    end

    year = dtbs_pkg::ext(s1_r.m_year) - dtbs_pkg::ext(s1_r.s_year)
         - dtbs_pkg::sval_t'({10'd0, s1_r.year_owe});
    cb   = (year < 0);
    if (cb) begin
      year = year + dtbs_pkg::YEAR_RADIX;
    end

    // A zero month difference reads as month one.
    mon = (s1_r.mon == 0) ? dtbs_pkg::MON_JAN : s1_r.mon;

    s2_nxt.hund     = s1_r.hund;
    s2_nxt.sec      = s1_r.sec;
    s2_nxt.min      = min[dtbs_pkg::FIELD_W-1:0];
    s2_nxt.hour     = hour[dtbs_pkg::FIELD_W-1:0];
    s2_nxt.hour_owe = hrb;
    s2_nxt.day_raw  = s1_r.day_raw;
    s2_nxt.mon      = mon;
    s2_nxt.leap     = (year[1:0] == 2'b00)
                   && ((mon == dtbs_pkg::MON_MAR) || (mon == dtbs_pkg::MON_APR));
    s2_nxt.year     = year;
    // Century takes the borrow with a plus sign; keep it that way.
    s2_nxt.cent     = dtbs_pkg::ext(s1_r.m_cent) - dtbs_pkg::ext(s1_r.s_cent)
                    + dtbs_pkg::sval_t'({10'd0, cb});
  end

  // Stage 3: day borrow and month step-back, into the output register.
  dtbs_window u_window (
    .stg (s2_r),
    .res (res)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_v_r <= in_tvalid;
      end
      if (adv_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload: advance with the stage, hold while stalled.
  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_r <= s1_nxt;
    end
    if (adv_s2) begin
      s2_r <= s2_nxt;
    end
    if (adv_out) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

// ===== bench/tb_datetime_borrow_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// tb_datetime_borrow_subtractor_core: self-checking bench for the subtractor
// Drives minuend/subtrahend date-time words through the stream input, predicts
// each field-wise difference with an independent borrow-chain model and
// compares every result word field by field, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_datetime_borrow_subtractor_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 25;
  localparam int N_RAND      = 360;   // per random phase, four phases
  localparam int TAIL_CYCLES = 8;     // pipeline is three deep
  localparam int PRINT_CAP   = 100;

  // Window lengths of the two-month day borrow.
  localparam int WIN_LONG    = 61;
  localparam int WIN_LONGEST = 62;
  localparam int WIN_SHORT   = 59;

  // One directed word: raw operands plus an optional hand-computed result.
  typedef struct packed {
    logic [31:0] m_time;
    logic [31:0] m_date;
    logic [31:0] s_time;
    logic [31:0] s_date;
    logic        typed;
    logic [63:0] want;
  } dir_row_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [dtbs_pkg::IN_W-1:0]   in_tdata   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [dtbs_pkg::OUT_W-1:0]  out_tdata;

  // Differences of words offered but not yet taken, and of words taken
  // whose result is still due.
  dtbs_pkg::res_t offer_q [$];
  dtbs_pkg::res_t due_q   [$];

  int   err_count   = 0;
  int   result_idx  = 0;
  int   cycle_count = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   hold_req    = 0;

  dir_row_t dir_rows [N_DIR];

  string field_names [8] = '{"hundredths", "second", "minute", "hour",
                             "day", "month", "year", "century"};

  datetime_borrow_subtractor_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Hard stop: far above the slowest legal run (every word waiting out both
  // the sender gaps and the receiver stalls, plus the long hold).
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still due",
               cycle_count, due_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Count every mismatch, print only the first PRINT_CAP so a dead block cannot
  // flood the log.
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Field-wise date-time difference with the borrow chain and the day
  // window borrow, every field wrapped to a byte at the end.
  function automatic dtbs_pkg::res_t predict_diff(input logic [dtbs_pkg::IN_W-1:0] w);
    int   mhu, msc, mmi, mhr, mdy, mmo, myr, mce;
    int   shu, ssc, smi, shr, sdy, smo, syr, sce;
    int   brw, yb, cb, leap, win, span, d;
    int   hund, sec, mins, hr, mon, yr, cent, day;
    dtbs_pkg::res_t r;
    mhu = w[7:0];     msc = w[15:8];    mmi = w[23:16];   mhr = w[31:24];
    mdy = w[39:32];   mmo = w[47:40];   myr = w[55:48];   mce = w[63:56];
    shu = w[71:64];   ssc = w[79:72];   smi = w[87:80];   shr = w[95:88];
    sdy = w[103:96];  smo = w[111:104]; syr = w[119:112]; sce = w[127:120];

    // Time chain: hundredths -> second -> minute -> hour -> day.
    brw  = 0;
    hund = mhu - shu;
    if (hund < 0) begin
      brw  = 1;
      hund += dtbs_pkg::HUND_RADIX;
    end
    sec = msc - ssc - brw;
    brw = 0;
    if (sec < 0) begin
      brw = 1;
      sec += dtbs_pkg::SEC_RADIX;
    end
    mins = mmi - smi - brw;
    brw  = 0;
    if (mins < 0) begin
      brw  = 1;
      mins += dtbs_pkg::MIN_RADIX;
    end
    hr  = mhr - shr - brw;
    brw = 0;
    if (hr < 0) begin
      brw = 1;
      hr  += dtbs_pkg::HOUR_RADIX;
    end

    // Date: month borrows from year, year from century. The century borrow
    // is added back, not subtracted; keep that.
    yb  = 0;
    mon = mmo - smo;
    if (mon < 0) begin
      yb  = 1;
      mon += dtbs_pkg::MONTH_RADIX;
    end
    cb = 0;
    yr = myr - syr - yb;
    if (yr < 0) begin
      cb = 1;
      yr += dtbs_pkg::YEAR_RADIX;
    end
    cent = mce - (sce - cb);

    if (mon == 0)
      mon = 1;
    // Two's complement low bits, so a still-negative year works too.
    leap = ((yr & 3) == 0 && (mon == dtbs_pkg::MON_MAR || mon == dtbs_pkg::MON_APR))
         ? 1 : 0;

    d   = mdy - sdy - brw;
    day = d;
    if (d <= 0) begin
      win  = d;
      span = 0;
      case (mon)
        dtbs_pkg::MON_DEC, dtbs_pkg::MON_OCT, dtbs_pkg::MON_JUL, dtbs_pkg::MON_MAY: begin
          win  = WIN_LONG;
          span = dtbs_pkg::SPAN_31;
        end
        dtbs_pkg::MON_NOV, dtbs_pkg::MON_AUG, dtbs_pkg::MON_JUN, dtbs_pkg::MON_JAN: begin
          win  = WIN_LONG;
          span = dtbs_pkg::SPAN_30;
        end
        dtbs_pkg::MON_FEB, dtbs_pkg::MON_SEP: begin
          win  = WIN_LONGEST;
          span = dtbs_pkg::SPAN_31;
        end
        dtbs_pkg::MON_MAR: begin
          win  = WIN_SHORT + leap;
          span = dtbs_pkg::SPAN_31;
        end
        dtbs_pkg::MON_APR: begin
          win  = WIN_SHORT + leap;
          span = dtbs_pkg::FEB_SPAN + leap;
        end
        default: ;  // unknown month: day simply doubles
      endcase
      // Step the month back two, wrapping into year and century.
      mon -= dtbs_pkg::MONTH_BACK;
      if (mon < 0) begin
        mon += dtbs_pkg::MONTH_RADIX;
        yr  -= 1;
        if (yr < 0) begin
          yr   = dtbs_pkg::YEAR_MAX;
          cent -= 1;
        end
      end
      day = win + d - span;
      if (day > 0)
        mon += 1;
    end

    r.hund = hund[7:0];
    r.sec  = sec[7:0];
    r.min  = mins[7:0];
    r.hour = hr[7:0];
    r.day  = day[7:0];
    r.mon  = mon[7:0];
    r.year = yr[7:0];
    r.cent = cent[7:0];
    return r;
  endfunction

  function automatic logic [31:0] plausible_time();
    return {8'($urandom_range(23)), 8'($urandom_range(59)),
            8'($urandom_range(59)), 8'($urandom_range(99))};
  endfunction

  // Calendar-like date; a wide month also reaches the unknown-month path.
  function automatic logic [31:0] plausible_date(input bit wide_month);
    logic [7:0] mon;
    mon = wide_month ? 8'($urandom_range(15, 0)) : 8'($urandom_range(12, 1));
    return {8'($urandom_range(99)), 8'($urandom_range(99)), mon,
            8'($urandom_range(31, 1))};
  endfunction

  // Mostly calendar-like operands with equal fields now and then, the rest
  // raw noise over the full byte range.
  function automatic logic [dtbs_pkg::IN_W-1:0] random_operands();
    logic [31:0] mt, md, st, sd;
    int          mode;
    mode = $urandom_range(9);
    if (mode >= 8)
      return {$urandom, $urandom, $urandom, $urandom};
    mt = plausible_time();
    st = plausible_time();
    md = plausible_date(mode == 7);
    sd = plausible_date(mode == 7);
    if ($urandom_range(4) == 0)
      sd[15:8] = md[15:8];
    if ($urandom_range(4) == 0)
      sd[7:0] = md[7:0];
    if ($urandom_range(4) == 0)
      sd[23:16] = md[23:16];
    if ($urandom_range(5) == 0)
      st = mt;
    return {sd, st, md, mt};
  endfunction

  // Offer one word, hold it until taken, then idle at the phase's rate
  // with junk on the data lines.
  task automatic send_word(input logic [dtbs_pkg::IN_W-1:0] w, input dtbs_pkg::res_t want);
    offer_q.push_back(want);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do
      @(posedge clk);
    while (!in_tready);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom, $urandom};
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every offered word has produced its result.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (offer_q.size() != 0 || due_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Receiver: random stalls at the current rate, or a long hold counted
  // here once one is requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Scoreboard: move the difference of each taken word into the due queue,
  // compare each delivered word with the oldest due difference. Both
  // handshakes are sampled on the values ahead of the edge.
  always @(posedge clk) begin : scoreboard
    dtbs_pkg::res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (offer_q.size() == 0)
          report_mismatch("input taken with no word offered");
        else
          due_q.push_back(offer_q.pop_front());
      end
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = due_q.pop_front();
          for (int i = 0; i < 8; i++)
            if (out_tdata[8*i +: 8] !== want[8*i +: 8])
              report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                        result_idx, field_names[i],
                                        out_tdata[8*i +: 8], want[8*i +: 8]));
        end
        result_idx++;
      end
    end
  end

  initial begin : stimulus
    dtbs_pkg::res_t            want;
    logic [dtbs_pkg::IN_W-1:0] w;

    // Date words: {century, year, month, day}; time words:
    // {hour, minute, second, hundredths}.
    dir_rows = '{
      // all zero: day borrow in month 1 wraps year and century
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, 64'hFF63_0C1F_0000_0000},
      // all ones: identical operands, same as all zero
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 64'hFF63_0C1F_0000_0000},
      // plain difference, no borrow anywhere
      '{32'h0C1E_1E32, 32'h1414_050A, 32'h010A_0A14, 32'h130A_0203,
        1'b1, 64'h010A_0307_0B14_141E},
      // extremes: largest minus zero, zero minus largest
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      // day borrow through each month's window, year 8 is a leap year
      '{32'h0C00_0000, 32'h1408_0105, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0205, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0305, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0405, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0505, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0605, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0705, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0805, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0905, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0A05, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0B05, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_0C05, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      // months 3 and 4 without the leap day
      '{32'h0C00_0000, 32'h1409_0305, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1409_0405, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      // zero month difference turns into month 1, day stays positive
      '{32'h0C00_0000, 32'h1408_0714, 32'h0C00_0000, 32'h1300_0705, 1'b0, '0},
      // unknown months 13 and 200: the day doubles
      '{32'h0C00_0000, 32'h1408_0D05, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      '{32'h0C00_0000, 32'h1408_C805, 32'h0C00_0000, 32'h1300_0014, 1'b0, '0},
      // full time borrow chain pulls the day to zero
      '{32'h0000_0000, 32'h1408_0602, 32'h0000_0001, 32'h1300_0001, 1'b0, '0},
      // month and year borrow, century borrow added back
      '{32'h0C00_0000, 32'h1400_0310, 32'h0C00_0000, 32'h1305_0501, 1'b0, '0},
      // month steps back below zero with year already zero
      '{32'h0C00_0000, 32'h1405_0101, 32'h0C00_0000, 32'h1305_0001, 1'b0, '0}
    };

    // Hold reset, release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed words, back to back.
    for (int i = 0; i < N_DIR; i++) begin
      w = {dir_rows[i].s_date, dir_rows[i].s_time,
           dir_rows[i].m_date, dir_rows[i].m_time};
      want = dir_rows[i].typed ? dtbs_pkg::res_t'(dir_rows[i].want) : predict_diff(w);
      send_word(w, want);
    end
    drain_results();

    // Random phases: {idle, stall} = none, sender, receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          // Long receiver hold while the sender keeps pushing: the pipe
          // fills and in_tready must drop.
          hold_req  = 80;
        end
        1: begin
          idle_pct  = 73;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 73;
        end
        default: begin
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      for (int n = 0; n < N_RAND; n++) begin
        w = random_operands();
        send_word(w, predict_diff(w));
      end
      // Pause the sender until every result is back.
      drain_results();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
